### hdl/header_tail_frame_finder_unit_assert.svh
// Assertion macros shared by the frame finder RTL.
`ifndef HEADER_TAIL_FRAME_FINDER_UNIT_ASSERT_SVH
`define HEADER_TAIL_FRAME_FINDER_UNIT_ASSERT_SVH

// Implication checked at each rising edge once reset is released.
`define HTF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define HTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/htf_pkg.sv
// Package: constants and types of the header/tail frame finder.
`timescale 1ns / 1ps

package htf_pkg;

    // Longest frame, header included, before the open frame is dropped.
    localparam int MAX_FRAME_LEN = 256;
    // Frame byte counter must hold MAX_FRAME_LEN itself.
    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    // Compare width for counter versus the 9-bit minimum length register.
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // Counter value at which the first body word leaves the window.
    localparam int BODY_START = 6;
    // Counter value right after the header.
    localparam logic [CNT_W-1:0] CNT_AFTER_HEADER = CNT_W'(2);

    localparam logic [8:0] MIN_LEN_FLOOR = 9'd8;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER_PAIR   = 2'd0;
    localparam logic [1:0] REG_TAIL_PAIR     = 2'd1;
    localparam logic [1:0] REG_MIN_FRAME_LEN = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] HEADER_PAIR_RST   = 16'h0FF0;
    localparam logic [15:0] TAIL_PAIR_RST     = 16'hF00F;
    localparam logic [8:0]  MIN_FRAME_LEN_RST = 9'd23;

    // One result word.
    typedef struct packed {
        logic       frame_dropped;
        logic [7:0] body_count;
        logic       frame_done;
        logic [7:0] body_index;
        logic [7:0] body_byte;
        logic       body_valid;
    } t_result;

endpackage

### hdl/header_tail_frame_finder_unit.sv
// Header/tail frame finder: the single module of the deframer.
`timescale 1ns / 1ps

// Byte-stream deframer. Each input word is one received byte. The unit hunts
// for the two header bytes (header_pair), then passes the frame body
// (address, function, control, data) out one byte per word with its index,
// holding the newest three bytes back so that checksum and tail are never
// emitted. A frame ends when the two newest bytes equal tail_pair, the frame
// is at least min_frame_len bytes long (floor 8) and the mod-256 sum of the
// body equals the checksum byte; the last body byte then carries tlast and
// the body count. A frame that reaches MAX_FRAME_LEN bytes is abandoned with
// a single drop word (tuser bit 1), and the consumer discards that frame's
// body. Hunting bytes and the three bytes after the header give no output.
// Throughput is one byte per cycle: each byte is handled by the running
// state update and the one-deep output register, and the input is stalled
// only while a result word waits and the output is not ready. The result
// word is registered; configuration writes apply from the next byte. The
// user must make them only while the stream is idle; the unit has no check.
module header_tail_frame_finder_unit
    import htf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] body_byte, [15:8] body_index,
                                        // [23:16] body_count
    output logic        m_axis_tlast,   // frame_done
    output logic [1:0]  m_axis_tuser    // [0] body_valid, [1] frame_dropped
);

`include "header_tail_frame_finder_unit_assert.svh"

    // Configuration registers
    logic [15:0] r_header_pair;
    logic [15:0] r_tail_pair;
    logic [8:0]  r_min_frame_len;

    // Frame state
    logic             r_in_frame;
    logic [7:0]       r_prev_byte;
    logic             r_have_prev;
    logic [7:0]       r_win [3];
    logic [7:0]       r_body_sum;
    logic [CNT_W-1:0] r_count;

    // Output register
    logic    r_out_valid;
    t_result r_out;

    // Next values
    logic             n_in_frame;
    logic [7:0]       n_prev_byte;
    logic             n_have_prev;
    logic [7:0]       n_win [3];
    logic [7:0]       n_body_sum;
    logic [CNT_W-1:0] n_count;
    t_result          n_out;
    logic             n_has_result;

    logic             in_acc;
    logic             hdr_hit;
    logic [CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] need_ext;
    logic [CMP_W-1:0] idx_full;
    logic [CMP_W-1:0] len_full;
    logic [7:0]       evicted;
    logic             emit;
    logic             done;
    logic             drop;

    // Accept a new word whenever the output slot is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pair   <= HEADER_PAIR_RST;
            r_tail_pair     <= TAIL_PAIR_RST;
            r_min_frame_len <= MIN_FRAME_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_HEADER_PAIR:   r_header_pair   <= i_cfg_wdata;
                REG_TAIL_PAIR:     r_tail_pair     <= i_cfg_wdata;
                REG_MIN_FRAME_LEN: r_min_frame_len <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Compare and sum terms for the incoming byte
    assign hdr_hit  = r_have_prev && (r_prev_byte == r_header_pair[15:8]) &&
                      (s_axis_tdata == r_header_pair[7:0]);
    assign cnt_inc  = r_count + CNT_W'(1);
    assign cnt_ext  = CMP_W'(cnt_inc);
    assign need_ext = (r_min_frame_len < MIN_LEN_FLOOR) ? CMP_W'(MIN_LEN_FLOOR)
                                                         : CMP_W'(r_min_frame_len);
    assign idx_full = cnt_ext - CMP_W'(BODY_START);
    assign len_full = cnt_ext - CMP_W'(BODY_START - 1);
    assign evicted  = r_win[0];
    assign emit     = cnt_ext >= CMP_W'(BODY_START);
    assign n_body_sum = (r_in_frame && emit) ? r_body_sum + evicted : r_body_sum;
    assign done     = r_in_frame && emit && (cnt_ext >= need_ext) &&
                      (r_win[2] == r_tail_pair[15:8]) &&
                      (s_axis_tdata == r_tail_pair[7:0]) &&
                      (n_body_sum == r_win[1]);
    assign drop     = r_in_frame && !done && (cnt_ext >= CMP_W'(MAX_FRAME_LEN));

    // Next state and result for one byte
    always_comb begin
        n_in_frame   = r_in_frame;
        n_prev_byte  = r_prev_byte;
        n_have_prev  = r_have_prev;
        n_win        = r_win;
        n_count      = r_count;
        n_out        = '0;
        n_has_result = 1'b0;
        if (!r_in_frame) begin
            // Hunt for the header pair
            if (hdr_hit) begin
                n_in_frame  = 1'b1;
                n_count     = CNT_AFTER_HEADER;
                n_have_prev = 1'b0;
                n_prev_byte = '0;
                n_win[0]    = '0;
                n_win[1]    = '0;
                n_win[2]    = '0;
            end else begin
                n_prev_byte = s_axis_tdata;
                n_have_prev = 1'b1;
            end
        end else begin
            // Advance the window and the frame length
            n_count  = cnt_inc;
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = s_axis_tdata;
            if (done) begin
                n_has_result     = 1'b1;
                n_out.body_valid = 1'b1;
                n_out.body_byte  = evicted;
                n_out.body_index = idx_full[7:0];
                n_out.frame_done = 1'b1;
                n_out.body_count = len_full[7:0];
                n_in_frame       = 1'b0;
                n_have_prev      = 1'b0;
                n_prev_byte      = '0;
            end else if (drop) begin
                n_has_result        = 1'b1;
                n_out.frame_dropped = 1'b1;
                n_in_frame          = 1'b0;
                n_have_prev         = 1'b0;
                n_prev_byte         = '0;
            end else if (emit) begin
                n_has_result     = 1'b1;
                n_out.body_valid = 1'b1;
                n_out.body_byte  = evicted;
                n_out.body_index = idx_full[7:0];
            end
        end
    end

    // Update frame state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_prev_byte <= '0;
            r_have_prev <= 1'b0;
            r_win[0]    <= '0;
            r_win[1]    <= '0;
            r_win[2]    <= '0;
            r_body_sum  <= '0;
            r_count     <= '0;
        end else if (in_acc) begin
            r_in_frame  <= n_in_frame;
            r_prev_byte <= n_prev_byte;
            r_have_prev <= n_have_prev;
            r_win       <= n_win;
            if (!r_in_frame && hdr_hit) begin
                r_body_sum <= '0;
            end else begin
                r_body_sum <= n_body_sum;
            end
            r_count     <= n_count;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_has_result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_has_result) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.body_count, r_out.body_index, r_out.body_byte};
    assign m_axis_tlast  = r_out.frame_done;
    assign m_axis_tuser  = {r_out.frame_dropped, r_out.body_valid};

    // Checks
    `HTF_ASSERT_IMPL(a_done_xor_drop, i_clk, i_rst_n, r_out_valid,
        !(r_out.frame_done && r_out.frame_dropped), "frame done and dropped together")
    `HTF_ASSERT_IMPL(a_done_has_byte, i_clk, i_rst_n, r_out_valid && r_out.frame_done,
        r_out.body_valid, "frame done without a body byte")
    `HTF_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, r_in_frame,
        (r_count >= CNT_AFTER_HEADER) && (CMP_W'(r_count) < CMP_W'(MAX_FRAME_LEN)),
        "frame counter out of range")
    `HTF_ASSERT_NEXT(a_end_hunts, i_clk, i_rst_n, in_acc && (done || drop),
        !r_in_frame && !r_have_prev, "frame end did not return to hunting")

endmodule

### verif/testbench.sv
// Testbench for the frame finder: framed byte streams checked against an in-bench deframer model.
`timescale 1ns / 1ps

module testbench;
    import htf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 1000;
    localparam int MAX_REPORTS   = 100;

    // What a generated frame carries inside its body before the real ending
    typedef enum int {INS_NONE, INS_BAD_SUM_TAIL, INS_VALID_TAIL} t_insert;

    // Deframer model plus the queue of result words it predicts
    class frame_tracker;
        logic [15:0] header_pair = HEADER_PAIR_RST;
        logic [15:0] tail_pair   = TAIL_PAIR_RST;
        logic [8:0]  min_len     = MIN_FRAME_LEN_RST;
        bit          in_frame;
        bit          have_prev;
        bit [7:0]    prev_byte;
        bit [7:0]    window [3];
        bit [7:0]    body_sum;
        int unsigned byte_total;
        t_result     expected_words [$];
        int          errors;

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_HEADER_PAIR:   header_pair = val;
                REG_TAIL_PAIR:     tail_pair = val;
                REG_MIN_FRAME_LEN: min_len = val[8:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted byte and queue the word it causes
        function void take_byte(bit [7:0] b);
            t_result     word;
            bit [7:0]    leaving;
            int unsigned need;
            bit          emit;
            bit          accept;
            bit          closing;
            word = '0;
            if (!in_frame) begin
                if (have_prev && prev_byte == header_pair[15:8] && b == header_pair[7:0]) begin
                    in_frame   = 1'b1;
                    byte_total = 2;
                    body_sum   = '0;
                    window     = '{default: '0};
                    have_prev  = 1'b0;
                    prev_byte  = '0;
                end else begin
                    prev_byte = b;
                    have_prev = 1'b1;
                end
                return;
            end

            // Shift the window; the byte falling out is body once past the header area
            byte_total++;
            leaving   = window[0];
            window[0] = window[1];
            window[1] = window[2];
            window[2] = b;
            emit = byte_total >= BODY_START;
            if (emit)
                body_sum += leaving;

            need = int'((min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len);
            accept = emit && byte_total >= need &&
                     window[1] == tail_pair[15:8] && window[2] == tail_pair[7:0] &&
                     body_sum == window[0];
            closing = accept || byte_total >= MAX_FRAME_LEN;

            // A drop replaces the body byte; acceptance wins over a drop
            if (emit && (accept || !closing)) begin
                word.body_valid = 1'b1;
                word.body_byte  = leaving;
                word.body_index = 8'(byte_total - BODY_START);
            end
            if (accept) begin
                word.frame_done = 1'b1;
                word.body_count = 8'(byte_total - BODY_START + 1);
            end else if (closing) begin
                word.frame_dropped = 1'b1;
            end
            if (closing) begin
                in_frame  = 1'b0;
                have_prev = 1'b0;
                prev_byte = '0;
            end
            if (emit)
                expected_words.insert(expected_words.size(), word);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        // Check one result word against the oldest prediction
        function void match_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word expected none, got %h", $time, got);
                return;
            end
            want = expected_words.pop_front();
            compare("body_valid", want.body_valid, got.body_valid);
            compare("body_byte", want.body_byte, got.body_byte);
            compare("body_index", want.body_index, got.body_index);
            compare("frame_done", want.frame_done, got.frame_done);
            compare("body_count", want.body_count, got.body_count);
            compare("frame_dropped", want.frame_dropped, got.frame_dropped);
        endfunction

        function void flag_leftover();
            if (expected_words.size() != 0) begin
                errors++;
                $display("%0t: result words expected %0d more, got none", $time,
                         expected_words.size());
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] body_byte, [15:8] body_index, [23:16] body_count
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;         // [0] body_valid, [1] frame_dropped

    frame_tracker tracker = new;

    logic [7:0]  stream_bytes [$];
    logic [15:0] cur_header = HEADER_PAIR_RST;
    logic [15:0] cur_tail   = TAIL_PAIR_RST;
    logic [8:0]  cur_min    = MIN_FRAME_LEN_RST;
    int          burst_left;
    int          gap_max;
    bit          hold_request;

    header_tail_frame_finder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sample both streams and the config port; check results before noting new bytes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_word(t_result'({m_axis_tuser[1], m_axis_tdata[23:16], m_axis_tlast,
                                              m_axis_tdata[15:8], m_axis_tdata[7:0],
                                              m_axis_tuser[0]}));
            if (i_cfg_we)
                tracker.write_reg(i_cfg_addr, i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata);
        end
    end

    // Receiver: stall on a rotating pattern, with one long hold-off on request
    initial begin : receiver
        bit [15:0] pattern;
        int        step;
        int        held;
        pattern = '1;
        step    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge i_clk);
            end
            if (step % 64 == 0)
                case ($urandom_range(0, 2))
                    0: pattern = '1;
                    1: pattern = 16'($urandom);
                    default: pattern = 16'($urandom & $urandom) | 16'h1;
                endcase
            m_axis_tready <= pattern[step % 16];
            step++;
        end
    end

    // Offer one byte, opening a fresh burst after a random gap when the last one ran out
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_queued();
        while (stream_bytes.size() > 0)
            send_byte(stream_bytes.pop_front());
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every predicted word, then let the pipeline settle
    task automatic wait_idle();
        int n;
        for (n = 0; n < DRAIN_LIMIT && tracker.pending() != 0; n++)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register; the caller lowers the write enable after the last one
    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_HEADER_PAIR:   cur_header = val;
            REG_TAIL_PAIR:     cur_tail = val;
            REG_MIN_FRAME_LEN: cur_min = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Append one byte to the outgoing stream
    function automatic void queue_byte(logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic logic [7:0] body_filler();
        // Mostly random, now and then a header or tail byte inside the body
        case ($urandom_range(0, 23))
            0: return cur_header[15:8];
            1: return cur_header[7:0];
            2: return cur_tail[15:8];
            3: return cur_tail[7:0];
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_noise(int count);
        repeat (count) queue_byte(8'($urandom));
    endfunction

    // Queue a frame: header, body with an optional embedded ending, then checksum and tail if closed
    function automatic void add_frame(int n_body, bit sum_ok, t_insert ins, bit closed);
        bit [7:0] acc;
        bit [7:0] b;
        int       at;
        int       i;
        acc = '0;
        at  = $urandom_range(0, n_body);
        queue_byte(cur_header[15:8]);
        queue_byte(cur_header[7:0]);
        for (i = 0; i <= n_body; i++) begin
            if (i == at && ins != INS_NONE) begin
                b = (ins == INS_VALID_TAIL) ? acc : acc + 8'd1;
                queue_byte(b);
                queue_byte(cur_tail[15:8]);
                queue_byte(cur_tail[7:0]);
                acc += b + cur_tail[15:8] + cur_tail[7:0];
            end
            if (i < n_body) begin
                b = body_filler();
                queue_byte(b);
                acc += b;
            end
        end
        if (closed) begin
            queue_byte(sum_ok ? acc : acc + 8'($urandom_range(1, 255)));
            queue_byte(cur_tail[15:8]);
            queue_byte(cur_tail[7:0]);
        end
    endfunction

    // Mostly complete frames sized to the current minimum; some noise and broken frames
    function automatic void build_random_phase();
        int need;
        int n_min;
        int pieces;
        int k;
        need   = int'((cur_min < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cur_min);
        n_min  = (need - 5 > 3) ? need - 5 : 3;
        pieces = $urandom_range(3, 8);
        for (k = 0; k < pieces; k++)
            case ($urandom_range(0, 9))
                0: add_noise($urandom_range(1, 6));
                1: add_frame($urandom_range(0, 10), 1'b1, INS_NONE, 1'b0);
                2: add_frame(n_min + $urandom_range(0, 8), 1'b0, INS_NONE, 1'b1);
                3: add_frame(n_min + $urandom_range(0, 8), 1'b1, INS_BAD_SUM_TAIL, 1'b1);
                4: add_frame($urandom_range(0, n_min + 4), 1'b1, INS_VALID_TAIL, 1'b1);
                default: add_frame(n_min + $urandom_range(0, 8), 1'b1, INS_NONE, 1'b1);
            endcase
    endfunction

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("header_tail_frame_finder_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int sent;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: minimum below the floor, shortest frame with extreme bytes,
        // tail byte not reused as header, false tail with a bad checksum
        gap_max = 0;
        put_reg(REG_MIN_FRAME_LEN, 16'd0);
        i_cfg_we <= 1'b0;
        stream_bytes = {8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hFF, 8'h00, 8'hFF, 8'hFE,
                        8'hF0, 8'h0F, 8'hF0};
        add_frame(2, 1'b1, INS_BAD_SUM_TAIL, 1'b1);
        send_queued();
        wait_idle();

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_BYTES) begin
            // Reconfigure while idle; a frame may still be open here
            case (phase)
                0: begin
                    put_reg(REG_HEADER_PAIR, 16'($urandom));
                    put_reg(REG_TAIL_PAIR, 16'($urandom));
                    put_reg(REG_MIN_FRAME_LEN, 16'(MIN_LEN_FLOOR));
                end
                1: begin
                    put_reg(REG_HEADER_PAIR, 16'h0000);
                    put_reg(REG_TAIL_PAIR, 16'hFFFF);
                    put_reg(REG_MIN_FRAME_LEN, 16'(MAX_FRAME_LEN));
                end
                2: begin
                    put_reg(REG_HEADER_PAIR, 16'hFFFF);
                    put_reg(REG_TAIL_PAIR, 16'h0000);
                    put_reg(REG_MIN_FRAME_LEN, 16'h01FF);
                end
                default: begin
                    if ($urandom_range(0, 1))
                        put_reg(REG_HEADER_PAIR, ($urandom_range(0, 3) == 0) ?
                                HEADER_PAIR_RST : 16'($urandom));
                    if ($urandom_range(0, 1))
                        put_reg(REG_TAIL_PAIR, ($urandom_range(0, 3) == 0) ?
                                TAIL_PAIR_RST : 16'($urandom));
                    if ($urandom_range(0, 1))
                        case ($urandom_range(0, 4))
                            0: put_reg(REG_MIN_FRAME_LEN, 16'($urandom_range(0, 7)));
                            1: put_reg(REG_MIN_FRAME_LEN, 16'(MIN_LEN_FLOOR));
                            2: put_reg(REG_MIN_FRAME_LEN, 16'(MIN_FRAME_LEN_RST));
                            default: put_reg(REG_MIN_FRAME_LEN, 16'($urandom_range(9, 40)));
                        endcase
                end
            endcase
            i_cfg_we <= 1'b0;

            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase

            case (phase)
                0: begin
                    // Back-pressure: hold the receiver off while bytes keep coming
                    gap_max = 0;
                    hold_request = 1'b1;
                    build_random_phase();
                    add_frame(3 + $urandom_range(0, 8), 1'b1, INS_NONE, 1'b1);
                end
                1: add_frame(MAX_FRAME_LEN - 5, 1'b1, INS_NONE, 1'b1);
                2: add_frame(MAX_FRAME_LEN - 5, 1'b1, INS_VALID_TAIL, 1'b1);
                default: build_random_phase();
            endcase

            sent += stream_bytes.size();
            send_queued();
            wait_idle();
            phase++;
        end

        tracker.flag_leftover();
        if (tracker.errors == 0)
            $display("header_tail_frame_finder_unit verification clean");
        else
            $display("header_tail_frame_finder_unit verification failed");
        $finish;
    end

endmodule
